// File: design/ircpwm_pkg.sv
package ircpwm_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned CH_W         = $clog2(NUM_CHANNELS);
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [4:0] LAST_SYMBOL    = 5'd17;
  localparam logic [3:0] CHECK_SEED     = 4'hF;
  localparam logic [1:0] NIBBLE_ONE_HI  = 2'b01;
  localparam logic [2:0] REFRESH_FRAMES = 3'd4;
  localparam logic [7:0] CHANNEL_MIN    = 8'd1;
  localparam logic [7:0] CHANNEL_MAX    = 8'd4;
  localparam logic [7:0] VALUE_MAX      = 8'd15;

  localparam logic [CFG_IDX_W-1:0] REG_MARK_LEN          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_ZERO_CYCLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_ONE_CYCLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_EDGE_CYCLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP_TICKS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_GAP_TICKS = 3'd6;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_SET     = 2'd1,
    ACT_REFRESH = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_BAD_VALUE   = 2'd2,
    ST_BUSY        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_PAUSE = 2'd2,
    PH_GAP   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [3:0]  mark_len;
    logic [7:0]  pause_zero_cycles;
    logic [7:0]  pause_one_cycles;
    logic [7:0]  pause_frame_edge_cycles;
    logic [2:0]  repeat_count;
    logic [15:0] repeat_gap_ticks;
    logic [15:0] refresh_gap_ticks;
  } cfg_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] channel;
    logic       port;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic    ir_level;
    logic    busy_res;
    status_e status;
  } result_t;

endpackage

// File: design/ircpwm_cfg_regs.sv
module ircpwm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [ircpwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ircpwm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ircpwm_pkg::cfg_t                    cfg_o
);
  import ircpwm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MARK_LEN:          cfg_d.mark_len                = cfg_data_i[3:0];
        REG_PAUSE_ZERO_CYCLES: cfg_d.pause_zero_cycles       = cfg_data_i[7:0];
        REG_PAUSE_ONE_CYCLES:  cfg_d.pause_one_cycles        = cfg_data_i[7:0];
        REG_PAUSE_EDGE_CYCLES: cfg_d.pause_frame_edge_cycles = cfg_data_i[7:0];
        REG_REPEAT_COUNT:      cfg_d.repeat_count            = cfg_data_i[2:0];
        REG_REPEAT_GAP_TICKS:  cfg_d.repeat_gap_ticks        = cfg_data_i[15:0];
        REG_REFRESH_GAP_TICKS: cfg_d.refresh_gap_ticks       = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark_len                <= 4'd6;
      cfg_q.pause_zero_cycles       <= 8'd10;
      cfg_q.pause_one_cycles        <= 8'd21;
      cfg_q.pause_frame_edge_cycles <= 8'd39;
      cfg_q.repeat_count            <= 3'd3;
      cfg_q.repeat_gap_ticks        <= 16'd2308;
      cfg_q.refresh_gap_ticks       <= 16'd385;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/ircpwm_seq.sv
module ircpwm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ircpwm_pkg::item_t    item_i,
  input  ircpwm_pkg::cfg_t     cfg_i,
  output ircpwm_pkg::result_t  res_o
);
  import ircpwm_pkg::*;

  logic [3:0]      a_vals_q [NUM_CHANNELS];
  logic [3:0]      a_vals_d [NUM_CHANNELS];
  logic [3:0]      b_vals_q [NUM_CHANNELS];
  logic [3:0]      b_vals_d [NUM_CHANNELS];
  phase_e          phase_q, phase_d;
  logic [15:0]     frame_bits_q, frame_bits_d;
  logic [4:0]      sym_pos_q, sym_pos_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [2:0]      frames_left_q, frames_left_d;
  logic [CH_W-1:0] cur_ch_q, cur_ch_d;
  logic            refresh_q, refresh_d;

  logic            level;
  status_e         status;
  logic            do_load;
  logic            next_frame;
  logic [2:0]      fl_dec;
  logic [16:0]     cnt_inc;
  logic [4:0]      mark_lim;
  logic [7:0]      pause_cyc;
  logic [8:0]      pause_lim;
  logic [15:0]     gap;
  logic            data_bit;
  logic [CH_W-1:0] set_idx;
  logic [3:0]      n1, n2, n3;

  assign cnt_inc  = {1'b0, cnt_q} + 17'd1;
  assign mark_lim = {((cfg_i.mark_len == 4'd0) ? 4'd1 : cfg_i.mark_len), 1'b0};
  assign gap      = refresh_q ? cfg_i.refresh_gap_ticks : cfg_i.repeat_gap_ticks;
  assign data_bit = frame_bits_q[4'(5'd16 - sym_pos_q)];
  assign set_idx  = CH_W'(item_i.channel - CHANNEL_MIN);

  always_comb begin
    if (sym_pos_q == 5'd0 || sym_pos_q >= LAST_SYMBOL) begin
      pause_cyc = cfg_i.pause_frame_edge_cycles;
    end else if (data_bit) begin
      pause_cyc = cfg_i.pause_one_cycles;
    end else begin
      pause_cyc = cfg_i.pause_zero_cycles;
    end
    pause_lim = {((pause_cyc == 8'd0) ? 8'd1 : pause_cyc), 1'b0};
  end

  always_comb begin
    a_vals_d      = a_vals_q;
    b_vals_d      = b_vals_q;
    phase_d       = phase_q;
    frame_bits_d  = frame_bits_q;
    sym_pos_d     = sym_pos_q;
    cnt_d         = cnt_q;
    frames_left_d = frames_left_q;
    cur_ch_d      = cur_ch_q;
    refresh_d     = refresh_q;
    level         = 1'b0;
    status        = ST_OK;
    do_load       = 1'b0;
    next_frame    = 1'b0;
    fl_dec        = frames_left_q;
    n1            = '0;
    n2            = '0;
    n3            = '0;

    case (item_i.action)
      ACT_TICK: begin
        case (phase_q)
          PH_MARK: begin
            level = ~cnt_q[0];
            if (cnt_inc >= 17'(mark_lim)) begin
              phase_d = PH_PAUSE;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc[15:0];
            end
          end
          PH_PAUSE: begin
            if (cnt_inc >= 17'(pause_lim)) begin
              cnt_d = '0;
              if (sym_pos_q >= LAST_SYMBOL) begin
                if (gap == 16'd0) begin
                  next_frame = 1'b1;
                end else begin
                  phase_d = PH_GAP;
                end
              end else begin
                sym_pos_d = sym_pos_q + 5'd1;
                phase_d   = PH_MARK;
              end
            end else begin
              cnt_d = cnt_inc[15:0];
            end
          end
          PH_GAP: begin
            if (cnt_inc >= {1'b0, gap}) begin
              cnt_d      = '0;
              next_frame = 1'b1;
            end else begin
              cnt_d = cnt_inc[15:0];
            end
          end
          default: ;
        endcase
      end
      ACT_SET: begin
        if (phase_q != PH_IDLE) begin
          status = ST_BUSY;
        end else if (item_i.channel < CHANNEL_MIN || item_i.channel > CHANNEL_MAX) begin
          status = ST_BAD_CHANNEL;
        end else if (item_i.value > VALUE_MAX) begin
          status = ST_BAD_VALUE;
        end else begin
          if (item_i.port) begin
            b_vals_d[set_idx] = item_i.value[3:0];
          end else begin
            a_vals_d[set_idx] = item_i.value[3:0];
          end
          cur_ch_d      = set_idx;
          refresh_d     = 1'b0;
          frames_left_d = (cfg_i.repeat_count == 3'd0) ? 3'd1 : cfg_i.repeat_count;
          do_load       = 1'b1;
        end
      end
      ACT_REFRESH: begin
        if (phase_q != PH_IDLE) begin
          status = ST_BUSY;
        end else begin
          cur_ch_d      = '0;
          refresh_d     = 1'b1;
          frames_left_d = REFRESH_FRAMES;
          do_load       = 1'b1;
        end
      end
      default: ;
    endcase

    // frame and its gap done: start the next one or go idle
    if (next_frame) begin
      fl_dec        = (frames_left_q != 3'd0) ? frames_left_q - 3'd1 : frames_left_q;
      frames_left_d = fl_dec;
      if (fl_dec == 3'd0) begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end else begin
        if (refresh_q) begin
          cur_ch_d = cur_ch_q + CH_W'(1);
        end
        do_load = 1'b1;
      end
    end

    if (do_load) begin
      n1           = {NIBBLE_ONE_HI, cur_ch_d};
      n2           = b_vals_d[cur_ch_d];
      n3           = a_vals_d[cur_ch_d];
      frame_bits_d = {n1, n2, n3, CHECK_SEED ^ n1 ^ n2 ^ n3};
      sym_pos_d    = '0;
      cnt_d        = '0;
      phase_d      = PH_MARK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        a_vals_q[i] <= '0;
        b_vals_q[i] <= '0;
      end
      phase_q       <= PH_IDLE;
      frame_bits_q  <= '0;
      sym_pos_q     <= '0;
      cnt_q         <= '0;
      frames_left_q <= '0;
      cur_ch_q      <= '0;
      refresh_q     <= 1'b0;
    end else if (step_i) begin
      a_vals_q      <= a_vals_d;
      b_vals_q      <= b_vals_d;
      phase_q       <= phase_d;
      frame_bits_q  <= frame_bits_d;
      sym_pos_q     <= sym_pos_d;
      cnt_q         <= cnt_d;
      frames_left_q <= frames_left_d;
      cur_ch_q      <= cur_ch_d;
      refresh_q     <= refresh_d;
    end
  end

  assign res_o.ir_level = level;
  assign res_o.busy_res = (phase_d != PH_IDLE);
  assign res_o.status   = status;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (frames_left_q != 3'd0))
    else $error("busy with no frames left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_pos_q <= LAST_SYMBOL)
    else $error("symbol position past stop symbol");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && status == ST_BUSY) |=> $stable(frames_left_q) && $stable(cur_ch_q))
    else $error("rejected command changed the sequencer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && level) |-> (phase_q == PH_MARK && item_i.action == ACT_TICK))
    else $error("carrier outside a mark");
`endif

endmodule

// File: design/ir_combo_pwm_frame_transmitter.sv
// an accepted input transaction is held in the input register, then processed into the result register
// throughput: one transaction per cycle while the result side does not stall
// the state update runs once per transaction in a single registered pass
// reset: asynchronous, active low; clears the stored values, the sequencer to idle,
// the configuration registers to their defaults and both pipeline stages to empty
module ir_combo_pwm_frame_transmitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [7:0]                         channel_i,
  input  logic                               port_i,
  input  logic [7:0]                         value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ir_level_o,
  output logic                               busy_res_o,
  output logic [1:0]                         status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ircpwm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ircpwm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ircpwm_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_accept;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;

  ircpwm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ircpwm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.action  <= action_e'(action_i);
      item_q.channel <= channel_i;
      item_q.port    <= port_i;
      item_q.value   <= value_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ir_level_o  = res_q.ir_level;
  assign busy_res_o  = res_q.busy_res;
  assign status_o    = res_q.status;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed transaction lost its result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !advance)
    else $error("result overwritten while stalled");
`endif

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import ircpwm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned QUIET_CAP = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action_in = '0;
  logic [7:0]            channel_in = '0;
  logic                  port_in = 1'b0;
  logic [7:0]            value_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  ir_level;
  logic                  busy_res;
  logic [1:0]            status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ir_combo_pwm_frame_transmitter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action_in),
    .channel_i   (channel_in),
    .port_i      (port_in),
    .value_i     (value_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .ir_level_o  (ir_level),
    .busy_res_o  (busy_res),
    .status_o    (status),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // transmitter state as predicted
  cfg_t shadow_cfg = '{mark_len: 4'd6, pause_zero_cycles: 8'd10, pause_one_cycles: 8'd21,
                       pause_frame_edge_cycles: 8'd39, repeat_count: 3'd3,
                       repeat_gap_ticks: 16'd2308, refresh_gap_ticks: 16'd385};
  logic [3:0]      level_a [NUM_CHANNELS] = '{default: '0};
  logic [3:0]      level_b [NUM_CHANNELS] = '{default: '0};
  phase_e          seq_phase = PH_IDLE;
  logic [15:0]     frame_word = '0;
  logic [4:0]      symbol_idx = '0;
  logic [15:0]     half_count = '0;
  logic [2:0]      frames_to_send = '0;
  logic [CH_W-1:0] active_channel = '0;
  logic            refreshing = 1'b0;

  result_t pending_results[$];
  int unsigned failures = 0;

  int unsigned burst_left = 0;
  bit          steady_sender = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_tick = 0;

  function automatic int unsigned at_least_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned frame_gap();
    return refreshing ? shadow_cfg.refresh_gap_ticks : shadow_cfg.repeat_gap_ticks;
  endfunction

  function automatic int unsigned pause_half_periods();
    int unsigned cyc;
    if (symbol_idx == 0 || symbol_idx >= LAST_SYMBOL) begin
      cyc = shadow_cfg.pause_frame_edge_cycles;
    end else if (frame_word[16 - symbol_idx]) begin
      cyc = shadow_cfg.pause_one_cycles;
    end else begin
      cyc = shadow_cfg.pause_zero_cycles;
    end
    return 2 * at_least_one(cyc);
  endfunction

  task automatic load_channel_frame();
    logic [3:0] n1, n2, n3;
    n1 = {NIBBLE_ONE_HI, active_channel};
    n2 = level_b[active_channel];
    n3 = level_a[active_channel];
    frame_word = {n1, n2, n3, CHECK_SEED ^ n1 ^ n2 ^ n3};
    symbol_idx = '0;
    half_count = '0;
    seq_phase = PH_MARK;
  endtask

  task automatic finish_frame();
    if (frames_to_send != 0) frames_to_send--;
    if (frames_to_send == 0) begin
      seq_phase = PH_IDLE;
      half_count = '0;
    end else begin
      if (refreshing) active_channel = active_channel + CH_W'(1);
      load_channel_frame();
    end
  endtask

  task automatic advance_half_period(output logic level);
    int unsigned cnt;
    level = 1'b0;
    cnt = half_count;
    case (seq_phase)
      PH_MARK: begin
        level = ~cnt[0];
        cnt++;
        if (cnt >= 2 * at_least_one(shadow_cfg.mark_len)) begin
          seq_phase = PH_PAUSE;
          cnt = 0;
        end
        half_count = cnt[15:0];
      end
      PH_PAUSE: begin
        cnt++;
        half_count = cnt[15:0];
        if (cnt >= pause_half_periods()) begin
          half_count = '0;
          if (symbol_idx >= LAST_SYMBOL) begin
            if (frame_gap() == 0) finish_frame();
            else seq_phase = PH_GAP;
          end else begin
            symbol_idx++;
            seq_phase = PH_MARK;
          end
        end
      end
      PH_GAP: begin
        cnt++;
        half_count = cnt[15:0];
        if (cnt >= frame_gap()) begin
          half_count = '0;
          finish_frame();
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
  endtask

  task automatic predict_result(input logic [1:0] act, input logic [7:0] ch, input logic p,
                                input logic [7:0] val);
    result_t r;
    logic lvl;
    logic busy;
    logic [CH_W-1:0] idx;
    lvl = 1'b0;
    r.status = ST_OK;
    busy = (seq_phase != PH_IDLE);
    case (act)
      ACT_TICK: advance_half_period(lvl);
      ACT_SET, ACT_REFRESH: begin
        if (busy) begin
          r.status = ST_BUSY;
        end else if (act == ACT_SET) begin
          if (ch < CHANNEL_MIN || ch > CHANNEL_MAX) begin
            r.status = ST_BAD_CHANNEL;
          end else if (val > VALUE_MAX) begin
            r.status = ST_BAD_VALUE;
          end else begin
            idx = CH_W'(ch - CHANNEL_MIN);
            if (p) level_b[idx] = val[3:0];
            else level_a[idx] = val[3:0];
            active_channel = idx;
            refreshing = 1'b0;
            frames_to_send = 3'(at_least_one(shadow_cfg.repeat_count));
            load_channel_frame();
          end
        end else begin
          active_channel = '0;
          refreshing = 1'b1;
          frames_to_send = REFRESH_FRAMES;
          load_channel_frame();
        end
      end
      default: ;
    endcase
    r.ir_level = lvl;
    r.busy_res = (seq_phase != PH_IDLE);
    pending_results.push_back(r);
  endtask

  // entered and left at a falling edge; valid stays high for the next transaction
  task automatic send_command(input logic [1:0] act, input logic [7:0] ch, input logic p,
                              input logic [7:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    action_in  <= act;
    channel_in <= ch;
    port_in    <= p;
    value_in   <= val;
    do @(posedge clk); while (in_stall);
    predict_result(act, ch, p, val);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_command(ACT_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic tick_to_quiet();
    int unsigned n;
    n = 0;
    while (seq_phase != PH_IDLE && n < QUIET_CAP) begin
      send_tick();
      n++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MARK_LEN:          shadow_cfg.mark_len = data[3:0];
      REG_PAUSE_ZERO_CYCLES: shadow_cfg.pause_zero_cycles = data[7:0];
      REG_PAUSE_ONE_CYCLES:  shadow_cfg.pause_one_cycles = data[7:0];
      REG_PAUSE_EDGE_CYCLES: shadow_cfg.pause_frame_edge_cycles = data[7:0];
      REG_REPEAT_COUNT:      shadow_cfg.repeat_count = data[2:0];
      REG_REPEAT_GAP_TICKS:  shadow_cfg.repeat_gap_ticks = data;
      REG_REFRESH_GAP_TICKS: shadow_cfg.refresh_gap_ticks = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // junk fills the bits above each register's width
  task automatic apply_settings(input cfg_t c, input logic [15:0] junk);
    drain_results();
    write_register(REG_MARK_LEN, {junk[15:4], c.mark_len});
    write_register(REG_PAUSE_ZERO_CYCLES, {junk[15:8], c.pause_zero_cycles});
    write_register(REG_PAUSE_ONE_CYCLES, {junk[15:8], c.pause_one_cycles});
    write_register(REG_PAUSE_EDGE_CYCLES, {junk[15:8], c.pause_frame_edge_cycles});
    write_register(REG_REPEAT_COUNT, {junk[15:3], c.repeat_count});
    write_register(REG_REPEAT_GAP_TICKS, c.repeat_gap_ticks);
    write_register(REG_REFRESH_GAP_TICKS, c.refresh_gap_ticks);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t small_settings();
    cfg_t c;
    c.mark_len                = 4'($urandom_range(0, 3));
    c.pause_zero_cycles       = 8'($urandom_range(0, 3));
    c.pause_one_cycles        = 8'($urandom_range(0, 4));
    c.pause_frame_edge_cycles = 8'($urandom_range(0, 3));
    c.repeat_count            = 3'($urandom_range(0, 3));
    c.repeat_gap_ticks        = 16'($urandom_range(0, 12));
    c.refresh_gap_ticks       = 16'($urandom_range(0, 12));
    return c;
  endfunction

  task automatic run_traffic(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (seq_phase == PH_IDLE && pick < 60) begin
        if (pick < 40) begin
          send_command(ACT_SET, 8'($urandom_range(1, 4)), 1'($urandom),
                       8'($urandom_range(0, 15)));
        end else begin
          send_command(ACT_REFRESH, 8'($urandom), 1'($urandom), 8'($urandom));
        end
      end else if (pick < 88) begin
        send_tick();
      end else if (pick < 92) begin
        send_command(ACT_SET, 8'($urandom_range(1, 4)), 1'($urandom),
                     8'($urandom_range(0, 15)));
      end else if (pick < 95) begin
        send_command(ACT_REFRESH, 8'($urandom), 1'($urandom), 8'($urandom));
      end else if (pick < 98) begin
        send_command(ACT_SET, 8'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        send_command(ACT_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_command_checks();
    send_command(ACT_TICK, 8'h00, 1'b0, 8'h00);
    send_command(ACT_TICK, 8'hFF, 1'b1, 8'hFF);
    send_command(ACT_UNUSED, 8'hA5, 1'b1, 8'h5A);
    send_command(ACT_SET, 8'd0, 1'b0, 8'd0);
    send_command(ACT_SET, 8'd5, 1'b0, 8'd3);
    send_command(ACT_SET, 8'hFF, 1'b1, 8'hFF);
    send_command(ACT_SET, 8'd1, 1'b0, 8'd16);
    send_command(ACT_SET, 8'd4, 1'b1, 8'hFF);
    send_command(ACT_SET, 8'd2, 1'b1, 8'd15);
    send_command(ACT_SET, 8'd3, 1'b0, 8'd0);
    send_command(ACT_SET, 8'd0, 1'b1, 8'hFF);
    send_command(ACT_REFRESH, 8'd0, 1'b0, 8'd0);
    send_command(ACT_UNUSED, 8'd1, 1'b0, 8'd1);
    repeat (8) send_tick();
  endtask

  task automatic test_zero_registers();
    apply_settings('0, 16'h0000);
    tick_to_quiet();
    send_command(ACT_SET, 8'd1, 1'b0, 8'd15);
    tick_to_quiet();
    send_command(ACT_SET, 8'd4, 1'b1, 8'd0);
    send_command(ACT_SET, 8'd4, 1'b0, 8'd15);
    tick_to_quiet();
  endtask

  task automatic test_random_phases();
    cfg_t c;
    apply_settings(small_settings(), 16'h0000);
    run_traffic(60);
    c = '{mark_len: 4'd15, pause_zero_cycles: 8'd255, pause_one_cycles: 8'd255,
          pause_frame_edge_cycles: 8'd255, repeat_count: 3'd7,
          repeat_gap_ticks: 16'hFFFF, refresh_gap_ticks: 16'hFFFF};
    apply_settings(c, 16'h0000);
    run_traffic(20);
    c = '{mark_len: 4'd1, pause_zero_cycles: 8'd1, pause_one_cycles: 8'd2,
          pause_frame_edge_cycles: 8'd1, repeat_count: 3'd7,
          repeat_gap_ticks: 16'd1, refresh_gap_ticks: 16'd0};
    apply_settings(c, 16'hFFFF);
    run_traffic(60);
    apply_settings(small_settings(), 16'($urandom));
    run_traffic(40);
  endtask

  task automatic test_input_backpressure();
    cfg_t c;
    c = small_settings();
    c.repeat_count = 3'd2;
    apply_settings(c, 16'h0000);
    send_command(ACT_SET, 8'd3, 1'b1, 8'd6);
    steady_sender = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_tick();
    steady_sender = 1'b0;
    run_traffic(40);
  endtask

  // result side stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_tick[7:6])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_tick % 5 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (ir_level !== want.ir_level) begin
          $error("ir_level: expected %0d, got %0d", want.ir_level, ir_level);
          failures++;
        end
        if (busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, busy_res);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_command_checks();
    test_zero_registers();
    test_random_phases();
    test_input_backpressure();
    drain_results();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
